// ===== rtl/core/ucs_pkg.sv =====
// ucs_pkg: shared types, codes and character classes of the URI component splitter.
// No dependencies; the result interface and the core use it by scoped names.
package ucs_pkg;

    localparam int IDX_W = 12;
    localparam logic [IDX_W-1:0] IDX_MAX = 12'hFFF;

    // Phase codes
    localparam logic [3:0] PH_SCHEME_FIRST = 4'd0;
    localparam logic [3:0] PH_SCHEME_REST  = 4'd1;
    localparam logic [3:0] PH_AFTER_COLON  = 4'd2;
    localparam logic [3:0] PH_AFTER_SLASH  = 4'd3;
    localparam logic [3:0] PH_AUTHORITY    = 4'd4;
    localparam logic [3:0] PH_PATH         = 4'd5;
    localparam logic [3:0] PH_QUERY        = 4'd6;
    localparam logic [3:0] PH_FRAGMENT     = 4'd7;
    localparam logic [3:0] PH_ERROR        = 4'd8;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SCHEME   = 3'd1;
    localparam logic [2:0] ST_QUERY    = 3'd2;
    localparam logic [2:0] ST_FRAGMENT = 3'd3;
    localparam logic [2:0] ST_OVERLONG = 3'd4;

    // Present flag bits
    localparam int FL_AUTH  = 0;
    localparam int FL_QUERY = 1;
    localparam int FL_FRAG  = 2;

    // Delimiters
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] error_position;
        logic [IDX_W-1:0] scheme_colon;
        logic             has_authority;
        logic [IDX_W-1:0] auth_limit;
        logic [IDX_W-1:0] path_limit;
        logic             has_query;
        logic [IDX_W-1:0] query_limit;
        logic             has_fragment;
        logic [IDX_W-1:0] frag_limit;
    } t_result;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    // unreserved, sub-delims, ':' and '@'
    function automatic logic is_pchar(input logic [7:0] c);
        logic sym;
        case (c)
            8'h2D, 8'h2E, 8'h5F, 8'h7E,                 // - . _ ~
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,   // ! $ & ' ( )
            8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D,          // * + , ; =
            8'h3A, 8'h40: begin                         // : @
                sym = 1'b1;
            end
            default: begin
                sym = 1'b0;
            end
        endcase
        is_pchar = is_alpha(c) || is_digit(c) || sym;
    endfunction

endpackage

// ===== rtl/core/ucs_if.sv =====
// ucs_if: valid/ready channel interfaces of the URI component splitter.
// Depends on ucs_pkg for index width.
interface ucs_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] ch;

    modport source (output valid, output kind, output ch, input ready);
    modport sink   (input valid, input kind, input ch, output ready);
endinterface

interface ucs_result_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic [ucs_pkg::IDX_W-1:0]   error_position;
    logic [ucs_pkg::IDX_W-1:0]   scheme_colon;
    logic                        has_authority;
    logic [ucs_pkg::IDX_W-1:0]   auth_limit;
    logic [ucs_pkg::IDX_W-1:0]   path_limit;
    logic                        has_query;
    logic [ucs_pkg::IDX_W-1:0]   query_limit;
    logic                        has_fragment;
    logic [ucs_pkg::IDX_W-1:0]   frag_limit;

    modport source (output valid, output status, output error_position, output scheme_colon,
                    output has_authority, output auth_limit, output path_limit,
                    output has_query, output query_limit, output has_fragment,
                    output frag_limit, input ready);
    modport sink   (input valid, input status, input error_position, input scheme_colon,
                    input has_authority, input auth_limit, input path_limit,
                    input has_query, input query_limit, input has_fragment,
                    input frag_limit, output ready);
endinterface

// ===== rtl/core/uri_component_splitter_core.sv =====
// uri_component_splitter_core: byte-serial URI splitter, top level.
// Depends on ucs_pkg and the channel interfaces in ucs_if.sv.
//
// The core takes URI text one beat per byte on i_item (kind 0 with a nonzero ch)
// and closes the text with an end beat (kind 1, or ch equal to zero). For each end
// beat it returns one beat on o_result with a status and the end index of the
// scheme, authority, path, query and fragment; begin indices follow from these
// (authority at scheme_colon+3 when present, path at auth_limit, query at
// path_limit+1, fragment one past the '#'). Byte beats return nothing. On an error
// the first one found wins, only status and error_position are nonzero, and the
// rest of the text is swallowed up to its end beat. Text beyond MAX_LEN bytes
// reports overlong at index MAX_LEN; every index saturates at 4095. The core
// accepts one beat per cycle, but an end beat waits while a result is held. A
// result is valid on o_result once its end beat has moved from the input
// register into the result register through the single phase update. A stalled
// result only holds back the next end beat; byte beats keep flowing behind it.
module uri_component_splitter_core #(
    parameter int MAX_LEN = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ucs_item_if.sink     i_item,
    ucs_result_if.source o_result
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int XW = (PW > ucs_pkg::IDX_W) ? PW : ucs_pkg::IDX_W;
    localparam logic [ucs_pkg::IDX_W-1:0] MAX_SAT =
        (MAX_LEN > 4095) ? ucs_pkg::IDX_MAX : ucs_pkg::IDX_W'(MAX_LEN);

    // Clamp a byte index to the 12-bit output range.
    function automatic logic [ucs_pkg::IDX_W-1:0] sat12(input logic [PW-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        sat12 = (x > XW'(4095)) ? ucs_pkg::IDX_MAX : x[ucs_pkg::IDX_W-1:0];
    endfunction

    // ---------------- input register ----------------
    logic       r_in_vld;
    logic       r_in_kind;
    logic [7:0] r_in_ch;

    // ---------------- parse state ----------------
    logic [3:0]                r_phase,        n_phase;
    logic [PW-1:0]             r_pos,          n_pos;
    logic [1:0]                r_hex,          n_hex;
    logic [ucs_pkg::IDX_W-1:0] r_pct,          n_pct;
    logic [2:0]                r_err_code,     n_err_code;
    logic [ucs_pkg::IDX_W-1:0] r_err_idx,      n_err_idx;
    logic [ucs_pkg::IDX_W-1:0] r_scheme_colon, n_scheme_colon;
    logic [ucs_pkg::IDX_W-1:0] r_auth_end,     n_auth_end;
    logic [ucs_pkg::IDX_W-1:0] r_path_limit,   n_path_limit;
    logic [ucs_pkg::IDX_W-1:0] r_query_limit,  n_query_limit;
    logic [ucs_pkg::IDX_W-1:0] r_frag_end,     n_frag_end;
    logic [2:0]                r_flags,        n_flags;

    // ---------------- result register ----------------
    logic             r_out_vld;
    ucs_pkg::t_result r_res, n_res;

    logic                      w_end;
    logic                      w_out_free;
    logic                      w_adv;
    logic [ucs_pkg::IDX_W-1:0] w_p12;
    logic                      w_take_path;
    logic                      w_take_tail;
    logic                      w_in_query;
    logic [2:0]                w_tail_code;

    // A zero byte ends the text just like an end beat.
    assign w_end      = r_in_kind | (r_in_ch == ucs_pkg::CH_NUL);
    assign w_out_free = ~r_out_vld | o_result.ready;
    // Byte beats never wait on the result side; end beats need a free result slot.
    assign w_adv      = r_in_vld & (~w_end | w_out_free);
    assign w_p12      = sat12(r_pos);
    assign w_in_query = (r_phase == ucs_pkg::PH_QUERY);
    assign w_tail_code = w_in_query ? ucs_pkg::ST_QUERY : ucs_pkg::ST_FRAGMENT;

    assign i_item.ready = ~r_in_vld | w_adv;

    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_hex          = r_hex;
        n_pct          = r_pct;
        n_err_code     = r_err_code;
        n_err_idx      = r_err_idx;
        n_scheme_colon = r_scheme_colon;
        n_auth_end     = r_auth_end;
        n_path_limit   = r_path_limit;
        n_query_limit  = r_query_limit;
        n_frag_end     = r_frag_end;
        n_flags        = r_flags;
        n_res          = r_res;
        w_take_path    = 1'b0;
        w_take_tail    = 1'b0;

        if (w_adv && !w_end) begin
            // ---- one text byte ----
            if (r_phase != ucs_pkg::PH_ERROR) begin
                if (r_pos >= PW'(MAX_LEN)) begin
                    n_phase    = ucs_pkg::PH_ERROR;
                    n_err_code = ucs_pkg::ST_OVERLONG;
                    n_err_idx  = MAX_SAT;
                end else begin
                    n_pos = r_pos + PW'(1);
                    case (r_phase)
                        ucs_pkg::PH_SCHEME_FIRST, ucs_pkg::PH_SCHEME_REST: begin
                            if (r_in_ch == ucs_pkg::CH_COLON) begin
                                n_scheme_colon = w_p12;
                                n_phase        = ucs_pkg::PH_AFTER_COLON;
                            end else if (ucs_pkg::is_alpha(r_in_ch) ||
                                         (r_phase == ucs_pkg::PH_SCHEME_REST &&
                                          (ucs_pkg::is_digit(r_in_ch) ||
                                           r_in_ch == ucs_pkg::CH_PLUS ||
                                           r_in_ch == ucs_pkg::CH_MINUS ||
                                           r_in_ch == ucs_pkg::CH_DOT))) begin
                                n_phase = ucs_pkg::PH_SCHEME_REST;
                            end else begin
                                n_phase    = ucs_pkg::PH_ERROR;
                                n_err_code = ucs_pkg::ST_SCHEME;
                                n_err_idx  = w_p12;
                            end
                        end
                        ucs_pkg::PH_AFTER_COLON: begin
                            n_auth_end = w_p12;
                            if (r_in_ch == ucs_pkg::CH_SLASH) begin
                                n_phase = ucs_pkg::PH_AFTER_SLASH;
                            end else begin
                                w_take_path = 1'b1;
                            end
                        end
                        ucs_pkg::PH_AFTER_SLASH: begin
                            if (r_in_ch == ucs_pkg::CH_SLASH) begin
                                n_flags[ucs_pkg::FL_AUTH] = 1'b1;
                                n_phase = ucs_pkg::PH_AUTHORITY;
                            end else begin
                                w_take_path = 1'b1;
                            end
                        end
                        ucs_pkg::PH_AUTHORITY: begin
                            if (r_in_ch == ucs_pkg::CH_SLASH || r_in_ch == ucs_pkg::CH_QMARK ||
                                r_in_ch == ucs_pkg::CH_HASH) begin
                                n_auth_end  = w_p12;
                                w_take_path = 1'b1;
                            end
                        end
                        ucs_pkg::PH_PATH: begin
                            w_take_path = 1'b1;
                        end
                        ucs_pkg::PH_QUERY, ucs_pkg::PH_FRAGMENT: begin
                            w_take_tail = 1'b1;
                        end
                        default: begin
                            n_phase = ucs_pkg::PH_ERROR;
                        end
                    endcase

                    // Path byte: '?' opens the query, '#' the fragment.
                    if (w_take_path) begin
                        if (r_in_ch == ucs_pkg::CH_QMARK) begin
                            n_path_limit = w_p12;
                            n_flags[ucs_pkg::FL_QUERY] = 1'b1;
                            n_phase = ucs_pkg::PH_QUERY;
                        end else if (r_in_ch == ucs_pkg::CH_HASH) begin
                            n_path_limit = w_p12;
                            n_flags[ucs_pkg::FL_FRAG] = 1'b1;
                            n_phase = ucs_pkg::PH_FRAGMENT;
                        end else begin
                            n_phase = ucs_pkg::PH_PATH;
                        end
                    end

                    // Query or fragment byte, with percent escapes.
                    if (w_take_tail) begin
                        if (r_hex != 2'd0) begin
                            if (ucs_pkg::is_hex(r_in_ch)) begin
                                n_hex = r_hex - 2'd1;
                            end else begin
                                n_phase    = ucs_pkg::PH_ERROR;
                                n_err_code = w_tail_code;
                                n_err_idx  = r_pct;
                            end
                        end else if (r_in_ch == ucs_pkg::CH_PERCENT) begin
                            n_hex = 2'd2;
                            n_pct = w_p12;
                        end else if (ucs_pkg::is_pchar(r_in_ch) ||
                                     r_in_ch == ucs_pkg::CH_QMARK ||
                                     r_in_ch == ucs_pkg::CH_SLASH) begin
                            n_hex = r_hex;
                        end else if (r_in_ch == ucs_pkg::CH_HASH && w_in_query) begin
                            n_query_limit = w_p12;
                            n_flags[ucs_pkg::FL_FRAG] = 1'b1;
                            n_phase = ucs_pkg::PH_FRAGMENT;
                        end else begin
                            n_phase    = ucs_pkg::PH_ERROR;
                            n_err_code = w_tail_code;
                            n_err_idx  = w_p12;
                        end
                    end
                end
            end
        end else if (w_adv) begin
            // ---- end of text: close the open component, then emit ----
            case (r_phase)
                ucs_pkg::PH_SCHEME_FIRST, ucs_pkg::PH_SCHEME_REST: begin
                    n_phase    = ucs_pkg::PH_ERROR;
                    n_err_code = ucs_pkg::ST_SCHEME;
                    n_err_idx  = w_p12;
                end
                ucs_pkg::PH_AFTER_COLON, ucs_pkg::PH_AUTHORITY: begin
                    n_auth_end   = w_p12;
                    n_path_limit = w_p12;
                end
                ucs_pkg::PH_AFTER_SLASH, ucs_pkg::PH_PATH: begin
                    n_path_limit = w_p12;
                end
                ucs_pkg::PH_QUERY, ucs_pkg::PH_FRAGMENT: begin
                    if (r_hex != 2'd0) begin
                        n_phase    = ucs_pkg::PH_ERROR;
                        n_err_code = w_tail_code;
                        n_err_idx  = r_pct;
                    end else if (w_in_query) begin
                        n_query_limit = w_p12;
                    end else begin
                        n_frag_end = w_p12;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            n_res = '0;
            if (n_phase == ucs_pkg::PH_ERROR) begin
                n_res.status         = n_err_code;
                n_res.error_position = n_err_idx;
            end else begin
                n_res.scheme_colon  = n_scheme_colon;
                n_res.has_authority = n_flags[ucs_pkg::FL_AUTH];
                n_res.auth_limit    = n_auth_end;
                n_res.path_limit    = n_path_limit;
                n_res.has_query     = n_flags[ucs_pkg::FL_QUERY];
                n_res.query_limit   = n_flags[ucs_pkg::FL_QUERY] ? n_query_limit : '0;
                n_res.has_fragment  = n_flags[ucs_pkg::FL_FRAG];
                n_res.frag_limit    = n_flags[ucs_pkg::FL_FRAG] ? n_frag_end : '0;
            end

            // Start over for the next text.
            n_phase        = ucs_pkg::PH_SCHEME_FIRST;
            n_pos          = '0;
            n_hex          = 2'd0;
            n_pct          = '0;
            n_err_code     = ucs_pkg::ST_OK;
            n_err_idx      = '0;
            n_scheme_colon = '0;
            n_auth_end     = '0;
            n_path_limit   = '0;
            n_query_limit  = '0;
            n_frag_end     = '0;
            n_flags        = 3'd0;
        end
    end

    // Input register: load on every accepted beat, drop once processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_kind <= i_item.kind;
            r_in_ch   <= i_item.ch;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= ucs_pkg::PH_SCHEME_FIRST;
            r_pos          <= '0;
            r_hex          <= 2'd0;
            r_pct          <= '0;
            r_err_code     <= ucs_pkg::ST_OK;
            r_err_idx      <= '0;
            r_scheme_colon <= '0;
            r_auth_end     <= '0;
            r_path_limit   <= '0;
            r_query_limit  <= '0;
            r_frag_end     <= '0;
            r_flags        <= 3'd0;
        end else begin
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_hex          <= n_hex;
            r_pct          <= n_pct;
            r_err_code     <= n_err_code;
            r_err_idx      <= n_err_idx;
            r_scheme_colon <= n_scheme_colon;
            r_auth_end     <= n_auth_end;
            r_path_limit   <= n_path_limit;
            r_query_limit  <= n_query_limit;
            r_frag_end     <= n_frag_end;
            r_flags        <= n_flags;
        end
    end

    // Result register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_end) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_end) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.status         = r_res.status;
    assign o_result.error_position = r_res.error_position;
    assign o_result.scheme_colon   = r_res.scheme_colon;
    assign o_result.has_authority  = r_res.has_authority;
    assign o_result.auth_limit     = r_res.auth_limit;
    assign o_result.path_limit     = r_res.path_limit;
    assign o_result.has_query      = r_res.has_query;
    assign o_result.query_limit    = r_res.query_limit;
    assign o_result.has_fragment   = r_res.has_fragment;
    assign o_result.frag_limit     = r_res.frag_limit;

    // ---------------- assertions ----------------
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.status != ucs_pkg::ST_OK) |->
        (r_res.scheme_colon == '0 && !r_res.has_authority && r_res.auth_limit == '0 &&
         r_res.path_limit == '0 && !r_res.has_query && r_res.query_limit == '0 &&
         !r_res.has_fragment && r_res.frag_limit == '0))
        else $error("error result carries component indices");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_end) |=>
        (r_phase == ucs_pkg::PH_SCHEME_FIRST && r_pos == '0 && r_flags == 3'd0 &&
         r_hex == 2'd0 && r_out_vld))
        else $error("state not cleared after end beat");

    a_hex_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hex != 2'd0) |->
        (r_hex <= 2'd2 && (r_phase == ucs_pkg::PH_QUERY ||
                           r_phase == ucs_pkg::PH_FRAGMENT ||
                           r_phase == ucs_pkg::PH_ERROR)))
        else $error("hex digits pending outside query or fragment");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_LEN))
        else $error("byte position beyond MAX_LEN");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_res.status <= ucs_pkg::ST_OVERLONG))
        else $error("status code out of range");

endmodule
